// ===== src/cgn_pkg.sv =====
package cgn_pkg;

  // Frame geometry limits
  localparam int MAX_ROWS  = 1024;
  localparam int MAX_COLS  = 1024;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
  localparam int COL_CNT_W = $clog2(MAX_COLS + 1);

  // Field and datapath widths
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int PIX_W     = 16;
  localparam int VAL_W     = PIX_W + 1;
  localparam int DIFF_W    = VAL_W + 3;
  localparam int MAG_W     = DIFF_W - 1;
  localparam int SUM_W     = 28;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_COLS = 1'b1;

  localparam logic [CFG_W-1:0] CFG_COUNT_RESET = CFG_W'(1024);

  typedef logic [SUM_W-1:0] sum_t;
  typedef logic signed [VAL_W-1:0] pix_val_t;

  // Per-pixel control that travels down the pipe
  typedef struct packed {
    logic use_pix;
    logic last_row;
    logic last_col;
  } pix_ctl_t;

  // Gradient stage contents
  typedef struct packed {
    logic              valid;
    pix_ctl_t          ctl;
    logic [MAG_W-1:0]  mag;
  } grad_t;

  // Clamp a count register to [1, hi]
  function automatic int clamp_count(input logic [CFG_W-1:0] value, input int hi);
    int v;
    v = int'(value);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

endpackage

// ===== src/column_gradient_norm.sv =====
// Channel   Direction  Handshake                    Payload
// pixel     in         pixel_valid / pixel_stall    first_value, second_value
// result    out        result_valid / result_stall  norm_times_two
// cfg       in         cfg_write                    cfg_index, cfg_data
//
// One pixel item per cycle while pixel_stall is low; the line store reads
// two rows and writes one on the same edge as the pixel is taken.
// The frame result is registered behind the input and gradient stages.
// pixel_stall rises only when a frame-closing item meets an untaken result.
// Synchronous reset clears positions, sums and valids; the line store is not
// cleared and needs no clearing pass.
module column_gradient_norm (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [cgn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cgn_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              pixel_valid,
  output logic                              pixel_stall,
  input  logic signed [cgn_pkg::PIX_W-1:0]  first_value,
  input  logic signed [cgn_pkg::PIX_W-1:0]  second_value,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [cgn_pkg::SUM_W-1:0]         norm_times_two
);

  logic [cgn_pkg::CFG_W-1:0]      active_rows;
  logic [cgn_pkg::CFG_W-1:0]      active_cols;
  logic [cgn_pkg::ROW_CNT_W-1:0]  rows;
  logic [cgn_pkg::COL_CNT_W-1:0]  cols;
  logic [cgn_pkg::ROW_W-1:0]      row_pos;
  logic [cgn_pkg::COL_W-1:0]      col_pos;
  logic [cgn_pkg::ROW_CNT_W-1:0]  row_inc;
  logic [cgn_pkg::COL_CNT_W-1:0]  col_inc;
  logic [cgn_pkg::ROW_W-1:0]      row_below;
  cgn_pkg::pix_val_t              pix_sum;
  cgn_pkg::pix_ctl_t              ctl_next;
  logic                           accept;

  logic                           a_valid;
  cgn_pkg::pix_ctl_t              a_ctl;
  cgn_pkg::pix_val_t              a_pix;
  logic                           a_ready;
  cgn_pkg::pix_val_t              stored_cur;
  cgn_pkg::pix_val_t              stored_next;
  cgn_pkg::grad_t                 b;
  logic                           b_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active_rows <= cgn_pkg::CFG_COUNT_RESET;
      active_cols <= cgn_pkg::CFG_COUNT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        cgn_pkg::CFG_ACTIVE_ROWS: active_rows <= cfg_data;
        cgn_pkg::CFG_ACTIVE_COLS: active_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rows = cgn_pkg::ROW_CNT_W'(cgn_pkg::clamp_count(active_rows, cgn_pkg::MAX_ROWS));
  assign cols = cgn_pkg::COL_CNT_W'(cgn_pkg::clamp_count(active_cols, cgn_pkg::MAX_COLS));

  // Decode frame position of the arriving item
  assign row_inc   = cgn_pkg::ROW_CNT_W'(row_pos) + cgn_pkg::ROW_CNT_W'(1);
  assign col_inc   = cgn_pkg::COL_CNT_W'(col_pos) + cgn_pkg::COL_CNT_W'(1);
  assign row_below = row_pos + cgn_pkg::ROW_W'(1);

  assign ctl_next.use_pix  = (col_pos != '0) && (row_inc < rows);
  assign ctl_next.last_row = (row_inc >= rows);
  assign ctl_next.last_col = (col_inc >= cols);

  assign pix_sum = cgn_pkg::VAL_W'(first_value) + cgn_pkg::VAL_W'(second_value);

  assign a_ready     = !a_valid || b_ready;
  assign pixel_stall = !a_ready;
  assign accept      = pixel_valid && !pixel_stall;

  // Advance the frame position on each item taken
  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (accept) begin
      if (ctl_next.last_row) begin
        row_pos <= '0;
        col_pos <= ctl_next.last_col ? '0 : col_pos + cgn_pkg::COL_W'(1);
      end else begin
        row_pos <= row_below;
      end
    end
  end

  // Input stage, aligned with the line store read data
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (b_ready) begin
      a_valid <= 1'b0;
    end
    if (accept) begin
      a_pix <= pix_sum;
      a_ctl <= ctl_next;
    end
  end

  cgn_line_store u_line_store (
    .clk          (clk),
    .rd_en        (accept),
    .rd_addr_cur  (row_pos),
    .rd_addr_next (row_below),
    .wr_en        (accept),
    .wr_addr      (row_pos),
    .wr_data      (pix_sum),
    .rd_data_cur  (stored_cur),
    .rd_data_next (stored_next)
  );

  cgn_grad u_grad (
    .clk         (clk),
    .rst         (rst),
    .a_valid     (a_valid),
    .a_ctl       (a_ctl),
    .a_pix       (a_pix),
    .stored_cur  (stored_cur),
    .stored_next (stored_next),
    .b_ready     (b_ready),
    .b           (b)
  );

  cgn_accum u_accum (
    .clk            (clk),
    .rst            (rst),
    .b              (b),
    .result_stall   (result_stall),
    .b_ready        (b_ready),
    .result_valid   (result_valid),
    .norm_times_two (norm_times_two)
  );

`ifndef SYNTHESIS
  a_input_hold: assert property (@(posedge clk) disable iff (rst)
    (a_valid && !b_ready) |=> (a_valid && $stable(a_pix) && $stable(a_ctl)))
    else $error("input stage lost its item while held");

  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && ctl_next.last_row) |=> (row_pos == '0))
    else $error("row position did not wrap at column end");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && ctl_next.last_row && ctl_next.last_col) |=> (col_pos == '0))
    else $error("column position did not wrap at frame end");
`endif

endmodule

// ===== src/cgn_line_store.sv =====
module cgn_line_store (
  input  logic                           clk,
  input  logic                           rd_en,
  input  logic [cgn_pkg::ROW_W-1:0]      rd_addr_cur,
  input  logic [cgn_pkg::ROW_W-1:0]      rd_addr_next,
  input  logic                           wr_en,
  input  logic [cgn_pkg::ROW_W-1:0]      wr_addr,
  input  cgn_pkg::pix_val_t              wr_data,
  output cgn_pkg::pix_val_t              rd_data_cur,
  output cgn_pkg::pix_val_t              rd_data_next
);

  cgn_pkg::pix_val_t mem [cgn_pkg::MAX_ROWS];

  // Read old contents before the write of the same edge lands
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_cur  <= mem[rd_addr_cur];
      rd_data_next <= mem[rd_addr_next];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

// ===== src/cgn_grad.sv =====
module cgn_grad (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 a_valid,
  input  cgn_pkg::pix_ctl_t    a_ctl,
  input  cgn_pkg::pix_val_t    a_pix,
  input  cgn_pkg::pix_val_t    stored_cur,
  input  cgn_pkg::pix_val_t    stored_next,
  input  logic                 b_ready,
  output cgn_pkg::grad_t       b
);

  logic signed [cgn_pkg::DIFF_W-1:0] diff;
  logic        [cgn_pkg::DIFF_W-1:0] diff_abs;
  logic                              advance;

  // Form 2*centre - below - right
  assign diff = (cgn_pkg::DIFF_W'(stored_cur) <<< 1)
              - cgn_pkg::DIFF_W'(stored_next)
              - cgn_pkg::DIFF_W'(a_pix);
  assign diff_abs = diff[cgn_pkg::DIFF_W-1] ? cgn_pkg::DIFF_W'(-diff) : diff;

  assign advance = a_valid && b_ready;

  // Hold or advance the gradient stage
  always_ff @(posedge clk) begin
    if (rst) begin
      b.valid <= 1'b0;
    end else if (advance) begin
      b.valid <= 1'b1;
    end else if (b_ready) begin
      b.valid <= 1'b0;
    end
    if (advance) begin
      b.ctl <= a_ctl;
      b.mag <= diff_abs[cgn_pkg::MAG_W-1:0];
    end
  end

endmodule

// ===== src/cgn_accum.sv =====
module cgn_accum (
  input  logic                        clk,
  input  logic                        rst,
  input  cgn_pkg::grad_t              b,
  input  logic                        result_stall,
  output logic                        b_ready,
  output logic                        result_valid,
  output logic [cgn_pkg::SUM_W-1:0]   norm_times_two
);

  cgn_pkg::sum_t              column_sum;
  cgn_pkg::sum_t              best_sum;
  logic [cgn_pkg::SUM_W:0]    sum_add;
  cgn_pkg::sum_t              sum_sat;
  cgn_pkg::sum_t              sum_now;
  cgn_pkg::sum_t              best_now;
  logic                       b_result;
  logic                       out_free;
  logic                       b_move;

  // Saturating column accumulate and running maximum
  assign sum_add  = {1'b0, column_sum} + (cgn_pkg::SUM_W + 1)'(b.mag);
  assign sum_sat  = sum_add[cgn_pkg::SUM_W] ? '1 : sum_add[cgn_pkg::SUM_W-1:0];
  assign sum_now  = b.ctl.use_pix ? sum_sat : column_sum;
  assign best_now = (sum_now > best_sum) ? sum_now : best_sum;

  // Only a frame-closing item waits for the result register
  assign b_result = b.ctl.last_row && b.ctl.last_col;
  assign out_free = !result_valid || !result_stall;
  assign b_move   = b.valid && (!b_result || out_free);
  assign b_ready  = !b.valid || b_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_sum   <= '0;
      best_sum     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (b_move) begin
        if (b.ctl.last_row) begin
          column_sum <= '0;
          if (b.ctl.last_col) begin
            best_sum       <= '0;
            norm_times_two <= best_now;
            result_valid   <= 1'b1;
          end else begin
            best_sum <= best_now;
          end
        end else begin
          column_sum <= sum_now;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_hold_final_item: assert property (@(posedge clk) disable iff (rst)
    (b.valid && b_result && result_valid && result_stall) |-> !b_ready)
    else $error("frame result would overwrite a waiting result");

  a_column_restart: assert property (@(posedge clk) disable iff (rst)
    (b_move && b.ctl.last_row) |=> (column_sum == '0))
    else $error("column sum not cleared at column end");

  a_frame_close: assert property (@(posedge clk) disable iff (rst)
    (b_move && b_result) |=> (result_valid && best_sum == '0))
    else $error("frame end did not present a result and clear the maximum");
`endif

endmodule

// ===== bench/column_gradient_norm_tb.sv =====
module column_gradient_norm_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     RESET_CYCLES  = 8;
  localparam int     SETTLE_CYCLES = 4;
  localparam int     DRAIN_CYCLES  = 8;
  localparam int     WHOLE_FRAME   = 1 << 30;
  localparam int     PHASE_ITEMS   = 190;
  localparam int     REPORT_LIMIT  = 10;
  localparam longint SUM_CEILING   = (longint'(1) << cgn_pkg::SUM_W) - 1;

  localparam logic signed [cgn_pkg::PIX_W-1:0] PIX_MAX = 16'sh7FFF;
  localparam logic signed [cgn_pkg::PIX_W-1:0] PIX_MIN = 16'sh8000;

  typedef enum int {FILL_RANDOM, FILL_SINGLE, FILL_BOUNDARY, FILL_CHECKER} fill_t;

  logic                             clk;
  logic                             rst;
  logic                             cfg_write;
  logic [cgn_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [cgn_pkg::CFG_W-1:0]        cfg_data;
  logic                             pixel_valid;
  logic                             pixel_stall;
  logic signed [cgn_pkg::PIX_W-1:0] first_value;
  logic signed [cgn_pkg::PIX_W-1:0] second_value;
  logic                             result_valid;
  logic                             result_stall;
  cgn_pkg::sum_t                    norm_times_two;

  column_gradient_norm dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pixel_valid    (pixel_valid),
    .pixel_stall    (pixel_stall),
    .first_value    (first_value),
    .second_value   (second_value),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .norm_times_two (norm_times_two)
  );

  // Frame norm predictor state
  cgn_pkg::pix_val_t         prev_column [cgn_pkg::MAX_ROWS];
  cgn_pkg::sum_t             column_acc;
  cgn_pkg::sum_t             best_acc;
  int                        row_at;
  int                        col_at;
  logic [cgn_pkg::CFG_W-1:0] rows_cfg;
  logic [cgn_pkg::CFG_W-1:0] cols_cfg;
  bit                        frame_closed;

  cgn_pkg::sum_t norm_expected [$];
  int            error_count;
  int            items_sent;
  int            send_idle_pct;
  int            recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Result side back-pressure
  initial begin
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic int effective_count(input logic [cgn_pkg::CFG_W-1:0] value,
                                         input int top);
    if (value == '0) return 1;
    if (int'(value) > top) return top;
    return int'(value);
  endfunction

  task automatic reset_norm_model();
    foreach (prev_column[i]) prev_column[i] = '0;
    column_acc = '0;
    best_acc = '0;
    row_at = 0;
    col_at = 0;
    rows_cfg = cgn_pkg::CFG_COUNT_RESET;
    cols_cfg = cgn_pkg::CFG_COUNT_RESET;
    frame_closed = 1'b0;
  endtask

  // Advance the norm predictor by one accepted pixel item
  task automatic advance_norm_model(input logic signed [cgn_pkg::PIX_W-1:0] a,
                                    input logic signed [cgn_pkg::PIX_W-1:0] b);
    cgn_pkg::pix_val_t v;
    int                rows;
    int                cols;
    longint            diff;
    longint            total;
    rows = effective_count(rows_cfg, cgn_pkg::MAX_ROWS);
    cols = effective_count(cols_cfg, cgn_pkg::MAX_COLS);
    v = cgn_pkg::pix_val_t'(a) + cgn_pkg::pix_val_t'(b);
    items_sent++;
    // gradient against the stored column: this row doubled, less row below and right
    if (col_at >= 1 && row_at + 1 < rows && row_at + 1 < cgn_pkg::MAX_ROWS) begin
      diff = 2 * longint'(prev_column[row_at]) - longint'(prev_column[row_at + 1])
             - longint'(v);
      if (diff < 0) diff = -diff;
      total = longint'(column_acc) + diff;
      column_acc = (total > SUM_CEILING) ? cgn_pkg::sum_t'(SUM_CEILING)
                                         : cgn_pkg::sum_t'(total);
    end
    if (row_at < cgn_pkg::MAX_ROWS) prev_column[row_at] = v;
    frame_closed = 1'b0;
    // close the column, and the frame on its last column
    if (row_at + 1 >= rows) begin
      if (column_acc > best_acc) best_acc = column_acc;
      column_acc = '0;
      row_at = 0;
      if (col_at + 1 >= cols) begin
        norm_expected = {norm_expected, best_acc};
        best_acc = '0;
        col_at = 0;
        frame_closed = 1'b1;
      end else begin
        col_at++;
      end
    end else begin
      row_at++;
    end
  endtask

  function automatic logic signed [cgn_pkg::PIX_W-1:0] boundary_value();
    case ($urandom_range(4))
      0: return PIX_MIN;
      1: return -16'sd1;
      2: return 16'sd0;
      3: return 16'sd1;
      default: return PIX_MAX;
    endcase
  endfunction

  function automatic void pick_pixel(input fill_t fill, input int r, input int c,
                                     output logic signed [cgn_pkg::PIX_W-1:0] a,
                                     output logic signed [cgn_pkg::PIX_W-1:0] b);
    case (fill)
      FILL_SINGLE: begin
        a = cgn_pkg::PIX_W'($urandom());
        b = '0;
      end
      FILL_BOUNDARY: begin
        a = boundary_value();
        b = boundary_value();
      end
      // alternate full-scale sums so every gradient is as large as it gets
      FILL_CHECKER: begin
        if ((r + c) % 2 == 0) begin
          a = PIX_MAX;
          b = PIX_MAX;
        end else begin
          a = PIX_MIN;
          b = PIX_MIN;
        end
      end
      default: begin
        a = cgn_pkg::PIX_W'($urandom());
        b = cgn_pkg::PIX_W'($urandom());
      end
    endcase
  endfunction

  // Offer one pixel item, hold it through any stall, then predict
  task automatic send_pixel(input logic signed [cgn_pkg::PIX_W-1:0] a,
                            input logic signed [cgn_pkg::PIX_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid  <= 1'b1;
    first_value  <= a;
    second_value <= b;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    advance_norm_model(a, b);
  endtask

  task automatic send_pixels(input fill_t fill, input int max_items);
    logic signed [cgn_pkg::PIX_W-1:0] a;
    logic signed [cgn_pkg::PIX_W-1:0] b;
    int                               count;
    count = 0;
    frame_closed = 1'b0;
    while (count < max_items && !frame_closed) begin
      pick_pixel(fill, row_at, col_at, a, b);
      send_pixel(a, b);
      count++;
    end
  endtask

  // Drop valid, drain pending frame results and let the pipe empty
  task automatic wait_idle();
    pixel_valid <= 1'b0;
    while (norm_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [cgn_pkg::CFG_IDX_W-1:0] index, input int value);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= cgn_pkg::CFG_W'(value);
    @(posedge clk);
    if (index == cgn_pkg::CFG_ACTIVE_ROWS) rows_cfg = cgn_pkg::CFG_W'(value);
    else cols_cfg = cgn_pkg::CFG_W'(value);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame_size(input int rows_value, input int cols_value);
    wait_idle();
    write_reg(cgn_pkg::CFG_ACTIVE_ROWS, rows_value);
    write_reg(cgn_pkg::CFG_ACTIVE_COLS, cols_value);
  endtask

  task automatic note_mismatch(input string what, input cgn_pkg::sum_t want,
                               input cgn_pkg::sum_t got);
    error_count++;
    if (error_count <= REPORT_LIMIT)
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $realtime, what, want, got);
  endtask

  // Compare each accepted result item with the oldest predicted norm
  always @(posedge clk) begin : check_results
    cgn_pkg::sum_t want;
    if (!rst && result_valid && !result_stall) begin
      if (norm_expected.size() == 0) begin
        note_mismatch("result with none pending", '0, norm_times_two);
      end else begin
        want = norm_expected.pop_front();
        if (norm_times_two !== want) note_mismatch("norm_times_two", want, norm_times_two);
      end
    end
  end

  // Tiny frames: full-scale and boundary pixels, zero counts, single-image form
  task automatic test_small_frames();
    send_idle_pct = 11;
    recv_idle_pct = 64;
    set_frame_size(2, 2);
    send_pixels(FILL_CHECKER, WHOLE_FRAME);
    send_pixels(FILL_BOUNDARY, WHOLE_FRAME);
    set_frame_size(0, 3);
    send_pixels(FILL_RANDOM, WHOLE_FRAME);
    set_frame_size(3, 0);
    send_pixels(FILL_BOUNDARY, WHOLE_FRAME);
    // back-to-back one-pixel frames pile results up behind the stall
    set_frame_size(1, 1);
    send_pixels(FILL_RANDOM, WHOLE_FRAME);
    send_pixels(FILL_BOUNDARY, WHOLE_FRAME);
    set_frame_size(3, 3);
    send_pixels(FILL_SINGLE, WHOLE_FRAME);
  endtask

  // Shrink both counts part way through a frame
  task automatic test_mid_frame_write();
    send_idle_pct = 11;
    recv_idle_pct = 64;
    set_frame_size(4, 4);
    send_pixels(FILL_RANDOM, 10);
    // row 2 of column 2 becomes the last row
    wait_idle();
    write_reg(cgn_pkg::CFG_ACTIVE_ROWS, 2);
    send_pixels(FILL_BOUNDARY, 2);
    // column 3 is already beyond the new count, so it closes the frame
    wait_idle();
    write_reg(cgn_pkg::CFG_ACTIVE_COLS, 2);
    send_pixels(FILL_RANDOM, WHOLE_FRAME);
  endtask

  // Row count above the store depth clamps to a full-height column
  task automatic test_count_extremes();
    send_idle_pct = 11;
    recv_idle_pct = 64;
    set_frame_size(2047, 1);
    send_pixels(FILL_BOUNDARY, WHOLE_FRAME);
  endtask

  task automatic run_random_phase(input int send_pct, input int recv_pct);
    int rows_value;
    int cols_value;
    int start_count;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start_count = items_sent;
    while (items_sent - start_count < PHASE_ITEMS) begin
      // mostly small frames, some taller ones, now and then a zero count
      if ($urandom_range(99) < 80) begin
        rows_value = int'($urandom_range(8, 1));
        cols_value = int'($urandom_range(8, 1));
      end else begin
        rows_value = int'($urandom_range(32, 2));
        cols_value = int'($urandom_range(12, 2));
      end
      if ($urandom_range(99) < 4) rows_value = 0;
      if ($urandom_range(99) < 4) cols_value = 0;
      set_frame_size(rows_value, cols_value);
      send_pixels(fill_t'($urandom_range(3)), WHOLE_FRAME);
    end
  endtask

  task automatic test_random_frames();
    run_random_phase(11, 64);
    run_random_phase(64, 11);
    run_random_phase(0, 0);
  endtask

  initial begin
    error_count = 0;
    items_sent = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    reset_norm_model();
    rst          <= 1'b1;
    cfg_write    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    pixel_valid  <= 1'b0;
    first_value  <= '0;
    second_value <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_small_frames();
    test_mid_frame_write();
    test_count_extremes();
    test_random_frames();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
